FILE: sv/dfsmc_pkg.sv
// Shared types and constants for the depth-first maze carver.
// Used by dfsmc_vmap and dfs_backtracker_maze_carver; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dfsmc_pkg;

  // default grid limit and configuration reset value
  localparam int MAX_SIDE_DEF = 32;
  localparam int SIDE_MIN     = 2;
  localparam int CFG_W        = 6;
  localparam logic [CFG_W-1:0] SIDE_RST = 6'd5;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SIDE = 1'b0;   // register index taken from paddr[2]

  // stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CELL_OUT_W  = 5;
  localparam int CNT_OUT_W   = 11;

  // item operations
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_ABORT = 2'd2
  } op_t;

  // directions, also the rotation order
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // result kinds
  typedef enum logic [2:0] {
    ACT_START  = 3'd0,
    ACT_CARVE  = 3'd1,
    ACT_BACK   = 3'd2,
    ACT_FINISH = 3'd3,
    ACT_IGNORE = 3'd4
  } act_t;

  // item sequencer
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD2  = 2'd1,
    S_EVAL = 2'd2,
    S_POP  = 2'd3
  } state_t;

  // control of the visited map
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } vmap_ctl_t;

endpackage

`default_nettype wire

FILE: sv/dfsmc_vmap.sv
// Visited map: one row of cell flags per memory word, two read ports, one write.
// Per-row valid flags give the clear-on-start without clearing the array. Uses dfsmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfsmc_vmap #(
  parameter int MAX_SIDE = dfsmc_pkg::MAX_SIDE_DEF,
  localparam int XW = $clog2(MAX_SIDE)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dfsmc_pkg::vmap_ctl_t ctl,
  input  wire logic [XW-1:0]        rd_a_addr,
  input  wire logic [XW-1:0]        rd_b_addr,
  input  wire logic [XW-1:0]        wr_addr,
  input  wire logic [MAX_SIDE-1:0]  wr_data,
  output logic      [MAX_SIDE-1:0]  rd_a_data,
  output logic      [MAX_SIDE-1:0]  rd_b_data
);

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] row_vld_r, row_vld_nxt;
  logic [MAX_SIDE-1:0] a_q_r, b_q_r;
  logic                a_v_r, b_v_r;

  // row valid flags: start drops them all, a write sets its row
  always_comb begin
    row_vld_nxt = ctl.clr ? '0 : row_vld_r;
    if (ctl.wr_en) begin
      row_vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else begin
      row_vld_r <= row_vld_nxt;
    end
  end

  // memory array, registered reads
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      a_q_r <= mem[rd_a_addr];
      b_q_r <= mem[rd_b_addr];
      a_v_r <= row_vld_r[rd_a_addr];
      b_v_r <= row_vld_r[rd_b_addr];
    end
  end

  // a row never written since start reads as all unvisited
  assign rd_a_data = a_v_r ? a_q_r : '0;
  assign rd_b_data = b_v_r ? b_q_r : '0;

endmodule

`default_nettype wire

FILE: sv/dfs_backtracker_maze_carver.sv
// Depth-first maze carver: item sequencer, path stack memory and stream ports.
// Uses dfsmc_pkg and dfsmc_vmap.
// Start, abort and ignored items are answered from the IDLE state.
// Step item: states IDLE, RD2 and EVAL for a carve or the last pop, then POP for a backtrack; three map rows are
// read over two read ports, and a backtrack adds the stack read of the new top.
// One item waits in the input register and one result in the output register.
// Reset (synchronous, rst_n low): empty stack, done, no cells visited; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module dfs_backtracker_maze_carver #(
  parameter int MAX_SIDE = dfsmc_pkg::MAX_SIDE_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [dfsmc_pkg::IN_TDATA_W-1:0]    in_tdata,  // [1:0] random_dir
  input  wire logic [1:0]                          in_tuser,  // [1:0] operation
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [4:0] cell_x, [9:5] cell_y, [11:10] step_dir, [22:12] visited_total
  output logic      [dfsmc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic      [2:0]                          out_tuser, // [2:0] action
  output logic                                     out_tlast, // finished
  // configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [dfsmc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [dfsmc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [dfsmc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int XW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);
  localparam int ARW   = 2 * SW;
  localparam int CW    = (DW > ARW) ? DW : ARW;
  localparam int CFW   = dfsmc_pkg::CFG_W;

  // configuration register
  logic [CFW-1:0] side_cfg_r;
  logic           cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == dfsmc_pkg::REG_SIDE) ?
                      dfsmc_pkg::CFG_DATA_W'(side_cfg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_cfg_r <= dfsmc_pkg::SIDE_RST;
    end else if (cfg_wr && cfg_paddr[2] == dfsmc_pkg::REG_SIDE) begin
      side_cfg_r <= cfg_pwdata[CFW-1:0];
    end
  end

  // state registers
  dfsmc_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]     side_r, side_nxt;
  logic [ARW-1:0]    area_r, area_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [DW-1:0]     cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [XW-1:0]     top_x_r, top_x_nxt;
  logic [XW-1:0]     top_y_r, top_y_nxt;

  // input register
  logic       ib_valid_r;
  logic [1:0] ib_op_r;
  logic [1:0] ib_dir_r;

  // output register
  logic                            out_valid_r;
  logic [dfsmc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [2:0]                      out_act_r;
  logic                            out_last_r;
  logic                            out_free;

  // visited map ports
  dfsmc_pkg::vmap_ctl_t vm_ctl;
  logic [XW-1:0]        vm_rd_a_addr, vm_rd_b_addr, vm_wr_addr;
  logic [MAX_SIDE-1:0]  vm_wr_data, vm_rd_a_data, vm_rd_b_data;
  logic [MAX_SIDE-1:0]  row_up_r, row_dn_r;

  // path stack, {y, x} per entry
  logic [2*XW-1:0] stk_mem [CELLS];
  logic [2*XW-1:0] stk_rd_r, stk_wd;
  logic [AW-1:0]   stk_wa, stk_ra;
  logic            stk_we, stk_re;

  // sequencer outputs
  logic       emit;
  logic [2:0] act;
  logic [1:0] sdir;
  logic       step_go;

  // neighbor evaluation
  logic [SW:0]     xp1, yp1;
  logic [XW-1:0]   x_inc, x_dec, y_inc, y_dec;
  logic [3:0]      opn;
  logic            found;
  logic [1:0]      pick;
  logic [XW-1:0]   nx, ny;
  logic [MAX_SIDE-1:0] row_sel;
  logic [SW-1:0]   side_clamp;
  logic [CW:0]     cnt_inc_ext;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !ib_valid_r || emit;

  // visited map instance
  dfsmc_vmap #(
    .MAX_SIDE(MAX_SIDE)
  ) u_vmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (vm_ctl),
    .rd_a_addr(vm_rd_a_addr),
    .rd_b_addr(vm_rd_b_addr),
    .wr_addr  (vm_wr_addr),
    .wr_data  (vm_wr_data),
    .rd_a_data(vm_rd_a_data),
    .rd_b_data(vm_rd_b_data)
  );

  // side clamp at start
  always_comb begin
    if (int'(side_cfg_r) < dfsmc_pkg::SIDE_MIN) begin
      side_clamp = SW'(dfsmc_pkg::SIDE_MIN);
    end else if (int'(side_cfg_r) > MAX_SIDE) begin
      side_clamp = SW'(MAX_SIDE);
    end else begin
      side_clamp = SW'(side_cfg_r);
    end
  end

  // neighbor bounds and visited flags of the stack-top cell
  always_comb begin
    xp1   = (SW + 1)'(top_x_r) + 1'b1;
    yp1   = (SW + 1)'(top_y_r) + 1'b1;
    x_inc = top_x_r + 1'b1;
    x_dec = top_x_r - 1'b1;
    y_inc = top_y_r + 1'b1;
    y_dec = top_y_r - 1'b1;
    opn[dfsmc_pkg::DIR_UP]    = (top_y_r != '0) && !row_up_r[top_x_r];
    opn[dfsmc_pkg::DIR_RIGHT] = (xp1 < (SW + 1)'(side_r)) && !vm_rd_a_data[x_inc];
    opn[dfsmc_pkg::DIR_DOWN]  = (yp1 < (SW + 1)'(side_r)) && !row_dn_r[top_x_r];
    opn[dfsmc_pkg::DIR_LEFT]  = (top_x_r != '0) && !vm_rd_a_data[x_dec];
  end

  // first open direction from the preferred one, rotating
  always_comb begin
    logic [1:0] d;
    found = 1'b0;
    pick  = '0;
    for (int k = 0; k < 4; k++) begin
      d = ib_dir_r + 2'(k);
      if (!found && opn[d]) begin
        found = 1'b1;
        pick  = d;
      end
    end
  end

  // chosen neighbor and the map row it lies in
  always_comb begin
    nx      = top_x_r;
    ny      = top_y_r;
    row_sel = vm_rd_a_data;
    case (pick)
      dfsmc_pkg::DIR_UP: begin
        ny      = y_dec;
        row_sel = row_up_r;
      end
      dfsmc_pkg::DIR_RIGHT: nx = x_inc;
      dfsmc_pkg::DIR_DOWN: begin
        ny      = y_inc;
        row_sel = row_dn_r;
      end
      default: nx = x_dec;
    endcase
  end

  assign cnt_inc_ext = (CW + 1)'(cnt_r) + 1'b1;
  assign step_go = ib_valid_r && ib_op_r == dfsmc_pkg::OP_STEP && !done_r && depth_r != '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dfsmc_pkg::S_IDLE: begin
        if (step_go) begin
          state_nxt = dfsmc_pkg::S_RD2;
        end
      end
      dfsmc_pkg::S_RD2: state_nxt = dfsmc_pkg::S_EVAL;
      dfsmc_pkg::S_EVAL: begin
        if (found || depth_r == DW'(1)) begin
          if (out_free) begin
            state_nxt = dfsmc_pkg::S_IDLE;
          end
        end else begin
          state_nxt = dfsmc_pkg::S_POP;
        end
      end
      dfsmc_pkg::S_POP: begin
        if (out_free) begin
          state_nxt = dfsmc_pkg::S_IDLE;
        end
      end
      default: state_nxt = dfsmc_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs and state updates
  always_comb begin
    emit         = 1'b0;
    act          = dfsmc_pkg::ACT_IGNORE;
    sdir         = '0;
    vm_ctl       = '0;
    vm_rd_a_addr = y_dec;
    vm_rd_b_addr = y_inc;
    vm_wr_addr   = ny;
    vm_wr_data   = row_sel | (MAX_SIDE'(1) << nx);
    stk_we       = 1'b0;
    stk_wa       = depth_r[AW-1:0];
    stk_wd       = {ny, nx};
    stk_re       = 1'b0;
    stk_ra       = AW'(depth_r - DW'(2));
    side_nxt     = side_r;
    area_nxt     = area_r;
    depth_nxt    = depth_r;
    cnt_nxt      = cnt_r;
    done_nxt     = done_r;
    top_x_nxt    = top_x_r;
    top_y_nxt    = top_y_r;
    unique case (state_r)
      dfsmc_pkg::S_IDLE: begin
        if (step_go) begin
          // fetch the rows above and below the top cell
          vm_ctl.rd_en = 1'b1;
        end else if (ib_valid_r && out_free) begin
          emit = 1'b1;
          case (ib_op_r)
            dfsmc_pkg::OP_START: begin
              act           = dfsmc_pkg::ACT_START;
              side_nxt      = side_clamp;
              area_nxt      = ARW'(side_clamp) * ARW'(side_clamp);
              vm_ctl.clr    = 1'b1;
              vm_ctl.wr_en  = 1'b1;
              vm_wr_addr    = '0;
              vm_wr_data    = MAX_SIDE'(1);
              stk_we        = 1'b1;
              stk_wa        = '0;
              stk_wd        = '0;
              depth_nxt     = DW'(1);
              cnt_nxt       = DW'(1);
              done_nxt      = 1'b0;
              top_x_nxt     = '0;
              top_y_nxt     = '0;
            end
            dfsmc_pkg::OP_STEP, dfsmc_pkg::OP_ABORT: begin
              // step with an empty stack, or abort of an active walk
              if (!done_r) begin
                act      = dfsmc_pkg::ACT_FINISH;
                done_nxt = 1'b1;
              end
            end
            default: act = dfsmc_pkg::ACT_IGNORE;
          endcase
        end
      end
      dfsmc_pkg::S_RD2: begin
        // fetch the top cell's own row
        vm_ctl.rd_en = 1'b1;
        vm_rd_a_addr = top_y_r;
        vm_rd_b_addr = top_y_r;
      end
      dfsmc_pkg::S_EVAL: begin
        if (found) begin
          // carve: mark, push, count
          if (out_free) begin
            emit         = 1'b1;
            sdir         = pick;
            vm_ctl.wr_en = 1'b1;
            stk_we       = 1'b1;
            depth_nxt    = depth_r + 1'b1;
            cnt_nxt      = cnt_r + 1'b1;
            top_x_nxt    = nx;
            top_y_nxt    = ny;
            if (cnt_inc_ext >= (CW + 1)'(area_r)) begin
              act      = dfsmc_pkg::ACT_FINISH;
              done_nxt = 1'b1;
            end else begin
              act = dfsmc_pkg::ACT_CARVE;
            end
          end
        end else if (depth_r == DW'(1)) begin
          // last entry popped
          if (out_free) begin
            emit      = 1'b1;
            act       = dfsmc_pkg::ACT_FINISH;
            done_nxt  = 1'b1;
            depth_nxt = '0;
            top_x_nxt = '0;
            top_y_nxt = '0;
          end
        end else begin
          // pop and fetch the entry below
          stk_re    = 1'b1;
          depth_nxt = depth_r - 1'b1;
        end
      end
      dfsmc_pkg::S_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          act       = dfsmc_pkg::ACT_BACK;
          top_x_nxt = stk_rd_r[XW-1:0];
          top_y_nxt = stk_rd_r[2*XW-1:XW];
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_ra];
    end
  end

  // neighbor rows held for evaluation
  always_ff @(posedge clk) begin
    if (state_r == dfsmc_pkg::S_RD2) begin
      row_up_r <= vm_rd_a_data;
      row_dn_r <= vm_rd_b_data;
    end
  end

  // control and walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfsmc_pkg::S_IDLE;
      side_r  <= SW'(dfsmc_pkg::SIDE_MIN);
      area_r  <= ARW'(dfsmc_pkg::SIDE_MIN * dfsmc_pkg::SIDE_MIN);
      depth_r <= '0;
      cnt_r   <= '0;
      done_r  <= 1'b1;
      top_x_r <= '0;
      top_y_r <= '0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
      area_r  <= area_nxt;
      depth_r <= depth_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      top_x_r <= top_x_nxt;
      top_y_r <= top_y_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      ib_valid_r <= 1'b1;
    end else if (emit) begin
      ib_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ib_op_r  <= in_tuser;
      ib_dir_r <= in_tdata[1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {1'b0, dfsmc_pkg::CNT_OUT_W'(cnt_nxt), sdir,
                     dfsmc_pkg::CELL_OUT_W'(top_y_nxt), dfsmc_pkg::CELL_OUT_W'(top_x_nxt)};
      out_act_r  <= act;
      out_last_r <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

  // an active walk always has a cell on the stack
  a_active_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> depth_r != '0)
    else $error("active walk with empty stack");

  // every stacked cell was counted as visited
  a_depth_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= cnt_r)
    else $error("stack deeper than visited count");

  // visited count never passes the grid area
  a_count_le_area: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(cnt_r) <= (CW + 1)'(area_r))
    else $error("visited count beyond grid area");

  // the second row fetch always follows the first
  a_rd2_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dfsmc_pkg::S_RD2 |-> $past(state_r) == dfsmc_pkg::S_IDLE)
    else $error("row fetch out of order");

endmodule

`default_nettype wire
